// ----- rtl/stepper_phase_sequencer_defines.svh -----
// Assertion macros shared by the stepper phase sequencer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef STEPPER_PHASE_SEQUENCER_DEFINES_SVH
`define STEPPER_PHASE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define SPS_ASSERT(name, clock, resetn, prop, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SPS_ASSERT_ALWAYS(name, clock, prop, msg) \
    name: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define SPS_ASSERT(name, clock, resetn, prop, msg)
`define SPS_ASSERT_ALWAYS(name, clock, prop, msg)

`endif

`endif

// ----- rtl/sps_pkg.sv -----
// Package for the stepper phase sequencer: request and mode codes, result type,
// coil tables and the fractional period table. No dependencies.
`timescale 1ns / 1ps

package sps_pkg;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_MODE = 2'd1,
        REQ_DIR  = 2'd2,
        REQ_KEY  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        MODE_WAVE = 2'd0,
        MODE_TWO  = 2'd1,
        MODE_HALF = 2'd2
    } mode_t;

    localparam logic [0:0] CFG_BASE_PERIOD = 1'b0;
    localparam logic [0:0] CFG_LOCKOUT     = 1'b1;

    localparam int unsigned STEP_BASE_RESET = 1000;
    localparam logic [5:0]  LOCKOUT_RESET   = 6'd51;
    localparam logic [3:0]  LEVEL_FULL      = 4'd10;
    localparam logic [7:0]  KEY_ZERO        = 8'h30;
    localparam logic [7:0]  KEY_NINE        = 8'h39;

    localparam logic [3:0] WAVE_TAB [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] TWO_TAB  [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
    localparam logic [3:0] HALF_TAB [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                            4'h4, 4'hC, 4'h8, 4'h9};

    typedef struct packed {
        logic [3:0] coils;
        logic       stepped;
        mode_t      drive_mode;
        logic       clockwise;
        logic       mode_locked;
        logic       dir_locked;
        logic [3:0] power_level;
    } result_t;

    function automatic logic [3:0] coil_pattern(mode_t mode, logic [2:0] idx);
        logic [3:0] pat;
        case (mode)
            MODE_WAVE: pat = WAVE_TAB[idx[1:0]];
            MODE_TWO:  pat = TWO_TAB[idx[1:0]];
            default:   pat = HALF_TAB[idx];
        endcase
        return pat;
    endfunction

    // floor(rem * level / 10) for rem 0..9, level 0..10; nibble n holds level n
    function automatic logic [3:0] frac_tenths(logic [3:0] rem, logic [3:0] level);
        logic [63:0] row;
        case (rem)
            4'd1:    row = 64'h0000_0100_0000_0000;
            4'd2:    row = 64'h0000_0211_1110_0000;
            4'd3:    row = 64'h0000_0322_2111_0000;
            4'd4:    row = 64'h0000_0433_2221_1000;
            4'd5:    row = 64'h0000_0544_3322_1100;
            4'd6:    row = 64'h0000_0654_4332_1100;
            4'd7:    row = 64'h0000_0765_4432_2100;
            4'd8:    row = 64'h0000_0876_5443_2100;
            4'd9:    row = 64'h0000_0987_6543_2100;
            default: row = 64'h0;
        endcase
        return row[{level, 2'b00} +: 4];
    endfunction

endpackage

// ----- rtl/sps_cfg.sv -----
// Configuration registers and step period for the stepper phase sequencer.
// Splits the base period into tenths at write time. Depends on sps_pkg.
`timescale 1ns / 1ps

module sps_cfg
    import sps_pkg::*;
#(
    parameter int PERIOD_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [15:0]            cfg_wdata,
    input  logic [3:0]             level,
    output logic [PERIOD_BITS-1:0] period,
    output logic [5:0]             lockout_steps
);

    localparam int QW      = PERIOD_BITS - 3;
    localparam int SHIFT   = PERIOD_BITS + 4;
    localparam int MAGIC_W = PERIOD_BITS + 1;
    localparam int PW      = PERIOD_BITS + MAGIC_W;
    localparam logic [MAGIC_W-1:0] MAGIC =
        MAGIC_W'(((64'd1 << SHIFT) + 64'd9) / 64'd10);
    localparam int unsigned RST_BASE = STEP_BASE_RESET % (1 << PERIOD_BITS);
    localparam logic [QW-1:0] RST_Q = QW'(RST_BASE / 10);
    localparam logic [3:0]    RST_R = 4'(RST_BASE % 10);

    logic [QW-1:0]            quot_reg;
    logic [3:0]               rem_reg;
    logic [5:0]               lockout_reg;
    logic [PERIOD_BITS+15:0]  wdata_ext;
    logic [PERIOD_BITS-1:0]   base;
    logic [PW-1:0]            prod;
    logic [QW-1:0]            quot_next;
    logic [PERIOD_BITS-1:0]   quot_x10;
    logic [PERIOD_BITS-1:0]   rem_wide;
    logic [QW+3:0]            quot_mul;
    logic [PERIOD_BITS-1:0]   period_sum;

    assign wdata_ext = {{PERIOD_BITS{1'b0}}, cfg_wdata};
    assign base      = wdata_ext[PERIOD_BITS-1:0];
    assign prod      = PW'(base) * PW'(MAGIC);
    assign quot_next = prod[PW-1:SHIFT];
    assign quot_x10  = {quot_next, 3'b000} + {2'b00, quot_next, 1'b0};
    assign rem_wide  = base - quot_x10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg    <= RST_Q;
            rem_reg     <= RST_R;
            lockout_reg <= LOCKOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_PERIOD:
                begin
                    quot_reg <= quot_next;
                    rem_reg  <= rem_wide[3:0];
                end
                CFG_LOCKOUT: lockout_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    assign quot_mul   = {4'b0000, quot_reg} * {{QW{1'b0}}, level};
    assign period_sum = quot_mul[PERIOD_BITS-1:0]
                      + PERIOD_BITS'(frac_tenths(rem_reg, level));

    always_comb
    begin
        period = period_sum;
        if (period_sum == '0)
        begin
            period = PERIOD_BITS'(1);
        end
    end

    assign lockout_steps = lockout_reg;

endmodule

// ----- rtl/sps_core.sv -----
// Input register and sequencer state for the stepper phase sequencer.
// Depends on sps_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "stepper_phase_sequencer_defines.svh"

module sps_core
    import sps_pkg::*;
#(
    parameter int PERIOD_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   out_free,
    input  logic [PERIOD_BITS-1:0] period,
    input  logic [5:0]             lockout_steps,
    output logic [3:0]             level,
    output logic                   res_load,
    output result_t                res
);

    logic                   in_valid_reg;
    req_t                   in_req_reg;
    logic [7:0]             in_key_reg;

    logic [2:0]             phase_reg, phase_next;
    mode_t                  mode_reg, mode_next;
    logic                   dir_reg, dir_next;
    logic [5:0]             lock_cnt_reg, lock_cnt_next;
    logic                   mode_lock_reg, mode_lock_next;
    logic                   dir_lock_reg, dir_lock_next;
    logic [PERIOD_BITS-1:0] tick_reg, tick_next;
    logic [3:0]             level_reg, level_next;
    logic [3:0]             coils_reg, coils_next;

    logic                   advance;
    logic                   stepped;
    logic                   half;
    logic [2:0]             last_idx;
    logic [2:0]             step_idx;
    logic [PERIOD_BITS:0]   tick_inc;

    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg <= req_t'(s_tuser);
            in_key_reg <= s_tdata;
        end
    end

    assign half     = (mode_reg != MODE_WAVE) && (mode_reg != MODE_TWO);
    assign last_idx = half ? 3'd7 : 3'd3;
    assign tick_inc = {1'b0, tick_reg} + {{PERIOD_BITS{1'b0}}, 1'b1};

    always_comb
    begin
        if (dir_reg)
        begin
            step_idx = (phase_reg >= last_idx) ? 3'd0 : phase_reg + 3'd1;
        end
        else
        begin
            step_idx = (phase_reg == 3'd0 || phase_reg > last_idx) ? last_idx
                                                                  : phase_reg - 3'd1;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        mode_next      = mode_reg;
        dir_next       = dir_reg;
        lock_cnt_next  = lock_cnt_reg;
        mode_lock_next = mode_lock_reg;
        dir_lock_next  = dir_lock_reg;
        tick_next      = tick_reg;
        level_next     = level_reg;
        coils_next     = coils_reg;
        stepped        = 1'b0;
        case (in_req_reg)
            REQ_TICK:
            begin
                if (level_reg == 4'd0)
                begin
                    tick_next = '0;
                end
                else if (tick_inc >= {1'b0, period})
                begin
                    tick_next  = '0;
                    stepped    = 1'b1;
                    phase_next = step_idx;
                    coils_next = coil_pattern(mode_reg, step_idx);
                    if (lock_cnt_reg != 6'd0)
                    begin
                        lock_cnt_next = lock_cnt_reg - 6'd1;
                    end
                    else
                    begin
                        mode_lock_next = 1'b0;
                        dir_lock_next  = 1'b0;
                    end
                end
                else
                begin
                    tick_next = tick_inc[PERIOD_BITS-1:0];
                end
            end
            REQ_MODE:
            begin
                if (!mode_lock_reg)
                begin
                    mode_lock_next = 1'b1;
                    lock_cnt_next  = lockout_steps;
                    case (mode_reg)
                        MODE_WAVE: mode_next = MODE_TWO;
                        MODE_TWO:  mode_next = MODE_HALF;
                        default:   mode_next = MODE_WAVE;
                    endcase
                end
            end
            REQ_DIR:
            begin
                if (!dir_lock_reg)
                begin
                    dir_lock_next = 1'b1;
                    lock_cnt_next = lockout_steps;
                    dir_next      = !dir_reg;
                end
            end
            default:
            begin
                if (in_key_reg >= KEY_ZERO && in_key_reg <= KEY_NINE)
                begin
                    level_next = in_key_reg[3:0];
                end
                else
                begin
                    level_next = LEVEL_FULL;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 3'd0;
            mode_reg      <= MODE_WAVE;
            dir_reg       <= 1'b1;
            lock_cnt_reg  <= 6'd0;
            mode_lock_reg <= 1'b0;
            dir_lock_reg  <= 1'b0;
            tick_reg      <= '0;
            level_reg     <= LEVEL_FULL;
            coils_reg     <= 4'd0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            dir_reg       <= dir_next;
            lock_cnt_reg  <= lock_cnt_next;
            mode_lock_reg <= mode_lock_next;
            dir_lock_reg  <= dir_lock_next;
            tick_reg      <= tick_next;
            level_reg     <= level_next;
            coils_reg     <= coils_next;
        end
    end

    assign level    = level_reg;
    assign res_load = advance;

    always_comb
    begin
        res.coils       = coils_next;
        res.stepped     = stepped;
        res.drive_mode  = mode_next;
        res.clockwise   = dir_next;
        res.mode_locked = mode_lock_next;
        res.dir_locked  = dir_lock_next;
        res.power_level = level_next;
    end

    `SPS_ASSERT(a_cnt_needs_lock, clk, rst_n, (lock_cnt_reg != 6'd0) |-> (mode_lock_reg || dir_lock_reg), "lockout count pending with no lock set")
    `SPS_ASSERT(a_mode_lock_loads, clk, rst_n, $rose(mode_lock_reg) |-> (lock_cnt_reg == $past(lockout_steps)), "mode lock set without loading lockout count")
    `SPS_ASSERT(a_step_drives, clk, rst_n, (advance && stepped) |-> (coils_next != 4'd0), "step produced an empty coil pattern")

endmodule

// ----- rtl/sps_out.sv -----
// Result register for the stepper phase sequencer: holds one item until taken
// and packs it onto the master stream. Depends on sps_pkg.
`timescale 1ns / 1ps

module sps_out
    import sps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata
);

    logic    valid_reg;
    result_t res_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, res_reg.power_level, res_reg.dir_locked,
                       res_reg.mode_locked, res_reg.clockwise, res_reg.drive_mode,
                       res_reg.stepped, res_reg.coils};

endmodule

// ----- rtl/stepper_phase_sequencer.sv -----
// Stepper phase sequencer top level: four-coil wave, two-phase and half-step
// drive. Depends on sps_pkg, sps_cfg, sps_core and sps_out.
`timescale 1ns / 1ps

// Takes one item per clock while the output side is ready (tick, mode button,
// direction button or key press) and returns exactly one result item per
// input, in order. An item is held in the input register, where the sequencer
// state updates in a single pass, and the result is then held in the output
// register until the output side takes it; an item waits in the input register
// while the output register is full and not being taken.
// Throughput is one item per cycle while the output side is ready.
// The step period is base * level / 10 ticks (minimum one); the base period
// register is split into tenths as it is written, so a write takes effect on
// the very next item. Write configuration only while no item is in flight.

module stepper_phase_sequencer
    import sps_pkg::*;
#(
    parameter int PERIOD_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_code
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [3:0] coils, [4] stepped, [6:5] drive_mode,
                                   // [7] clockwise, [8] mode_locked,
                                   // [9] dir_locked, [13:10] power_level, [15:14] 0
);

    logic [PERIOD_BITS-1:0] period;
    logic [5:0]             lockout_steps;
    logic [3:0]             level;
    logic                   out_free;
    logic                   res_load;
    result_t                res;

    sps_cfg #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .level         (level),
        .period        (period),
        .lockout_steps (lockout_steps)
    );

    sps_core #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .out_free      (out_free),
        .period        (period),
        .lockout_steps (lockout_steps),
        .level         (level),
        .res_load      (res_load),
        .res           (res)
    );

    sps_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
